@@ hdl/sstf_pkg.sv @@
// Shared types and constants of the shortest-seek-time-first request scheduler.
`default_nettype none

package sstf_pkg;

    // Fixed widths of the transaction fields.
    localparam int ID_W       = 6;
    localparam int IN_TRACK_W = 16;
    localparam int LIMIT_W    = 5;
    localparam int ACTIVE_W   = 7;
    localparam int STATUS_W   = 2;
    localparam int PEND_W     = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Command codes.
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_RETIRE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_QUEUE_LIMIT       = 1'b0;
    localparam logic REG_ACTIVE_REQUESTERS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0]  QUEUE_LIMIT_RST = 5'd16;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST      = 7'd0;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DECIDE
    } seq_state_t;

endpackage : sstf_pkg

`default_nettype wire

@@ hdl/sstf_disk_request_scheduler_top.sv @@
// Top level of the shortest-seek-time-first disk request scheduler.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// command selects submit (requester_id, request_track) or retire of a requester.
// Each transaction gives exactly one result, shown for one cycle with done high:
// status, dispatched, served_requester, served_track and pending_count.
// The receiver cannot stall the block; done is a strobe and must be sampled.
// Timing: the pending slots sit in a small RAM with a registered read port and
// are read one per cycle, while one shared distance unit tracks the nearest
// entry and a comparator tracks the requester match. The sequencer scans every
// pending entry and then decides; a new transaction may be started in the
// cycle that done is high, but none is taken while one is in progress.
// The RAM scan sets how long a transaction takes.
// Configuration: an APB port, pready always high; queue_limit at address 0 and
// active_requesters at 4; the user writes only while busy is low, not enforced.
// Reset: rst_n clears the queue, the head track and the retire count, and
// loads queue_limit with 16 and active_requesters with 0. Slot contents are
// not cleared; only written slots are ever read.
`default_nettype none

module sstf_disk_request_scheduler_top
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command channel
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic                  command,
    input  wire logic [ID_W-1:0]       requester_id,
    input  wire logic [IN_TRACK_W-1:0] request_track,
    // Result channel
    output      logic                  done,
    output      logic [STATUS_W-1:0]   status,
    output      logic                  dispatched,
    output      logic [ID_W-1:0]       served_requester,
    output      logic [IN_TRACK_W-1:0] served_track,
    output      logic [PEND_W-1:0]     pending_count,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int TW = (TRACK_BITS < IN_TRACK_W) ? TRACK_BITS : IN_TRACK_W;
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = ID_W + TW;

    seq_state_t state_reg, state_next;

    logic                  cmd_reg, cmd_next;
    logic [ID_W-1:0]       rid_reg, rid_next;
    logic [TW-1:0]         trk_reg, trk_next;
    logic [SW-1:0]         size_reg, size_next;
    logic [TW-1:0]         head_reg, head_next;
    logic [ACTIVE_W-1:0]   retired_reg, retired_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic [SW-1:0]         issue_reg, issue_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  match_reg, match_next;
    logic                  best_vld_reg, best_vld_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [TW-1:0]         best_dist_reg, best_dist_next;
    logic [ID_W-1:0]       best_id_reg, best_id_next;
    logic [TW-1:0]         best_trk_reg, best_trk_next;
    logic [DW-1:0]         last_reg, last_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  disp_reg, disp_next;
    logic [ID_W-1:0]       srid_reg, srid_next;
    logic [IN_TRACK_W-1:0] strk_reg, strk_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;

    // RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    // Shared seek unit
    logic [TW-1:0] seek_cand;
    logic [TW-1:0] seek_dist;
    logic          seek_closer;

    // Threshold and decision terms
    logic [ACTIVE_W-1:0] live;
    logic [ACTIVE_W-1:0] lim;
    logic [ACTIVE_W-1:0] thr;
    logic                cfg_wr;
    logic                is_full;
    logic                accepted;
    logic [SW-1:0]       size_mid;
    logic                dispatch;
    logic                new_best;
    logic [ID_W-1:0]     fin_id;
    logic [TW-1:0]       fin_trk;

    sstf_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The seek unit sees RAM data while scanning and the new request when deciding.
    assign seek_cand = (state_reg == SEQ_DECIDE) ? trk_reg : ram_rdata[TW-1:0];

    sstf_seek #(
        .W (TW)
    ) u_seek (
        .cand_track (seek_cand),
        .head_track (head_reg),
        .best_dist  (best_dist_reg),
        .best_vld   (best_vld_reg),
        .gap        (seek_dist),
        .closer     (seek_closer)
    );

    // Dispatch threshold: min(live requesters, queue limit capped at the depth).
    always_comb
    begin
        if (retired_reg < active_reg)
        begin
            live = active_reg - retired_reg;
        end
        else
        begin
            live = '0;
        end
        if (limit_reg > QUEUE_DEPTH)
        begin
            lim = ACTIVE_W'(QUEUE_DEPTH);
        end
        else
        begin
            lim = ACTIVE_W'(limit_reg);
        end
        thr = (live < lim) ? live : lim;
    end

    // Decision terms used in the decide state.
    always_comb
    begin
        is_full  = (size_reg >= thr) || (size_reg >= SW'(QUEUE_DEPTH));
        accepted = (cmd_reg == CMD_SUBMIT) && !match_reg && !is_full;
        size_mid = size_reg + SW'(accepted);
        dispatch = (size_mid != '0) && (size_mid >= thr);
        new_best = accepted && seek_closer;
        fin_id   = new_best ? rid_reg : best_id_reg;
        fin_trk  = new_best ? trk_reg : best_trk_reg;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                if (issue_reg == size_reg)
                begin
                    state_next = SEQ_DECIDE;
                end
            end
            SEQ_DECIDE:
            begin
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath.
    always_comb
    begin
        cmd_next       = cmd_reg;
        rid_next       = rid_reg;
        trk_next       = trk_reg;
        size_next      = size_reg;
        head_next      = head_reg;
        retired_next   = retired_reg;
        limit_next     = limit_reg;
        active_next    = active_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        match_next     = match_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_id_next   = best_id_reg;
        best_trk_next  = best_trk_reg;
        last_next      = last_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        disp_next      = disp_reg;
        srid_next      = srid_reg;
        strk_next      = strk_reg;
        pend_next      = pend_reg;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = {rid_reg, trk_reg};
        ram_re         = 1'b0;
        ram_raddr      = issue_reg[IW-1:0];

        // Register writes are to be taken only while the sequencer is idle; the user must ensure it.
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_QUEUE_LIMIT:
                begin
                    limit_next = pwdata[LIMIT_W-1:0];
                end
                REG_ACTIVE_REQUESTERS:
                begin
                    active_next = pwdata[ACTIVE_W-1:0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end

        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = command;
                    rid_next      = requester_id;
                    trk_next      = request_track[TW-1:0];
                    issue_next    = '0;
                    match_next    = 1'b0;
                    best_vld_next = 1'b0;
                    if (command == CMD_RETIRE)
                    begin
                        if (retired_reg < active_reg)
                        begin
                            retired_next = retired_reg + ACTIVE_W'(1);
                        end
                        else
                        begin
                            retired_next = active_reg;
                        end
                    end
                end
            end
            SEQ_SCAN:
            begin
                // Issue one slot read a cycle.
                if (issue_reg != size_reg)
                begin
                    ram_re      = 1'b1;
                    issue_next  = issue_reg + SW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[IW-1:0];
                end
                // Evaluate the slot read in the previous cycle.
                if (rd_vld_reg)
                begin
                    last_next = ram_rdata;
                    if (ram_rdata[DW-1:TW] == rid_reg)
                    begin
                        match_next = 1'b1;
                    end
                    if (seek_closer)
                    begin
                        best_vld_next  = 1'b1;
                        best_idx_next  = rd_idx_reg;
                        best_dist_next = seek_dist;
                        best_id_next   = ram_rdata[DW-1:TW];
                        best_trk_next  = ram_rdata[TW-1:0];
                    end
                end
            end
            SEQ_DECIDE:
            begin
                // Slot write-back: store the new request, or fill the served hole.
                if (dispatch)
                begin
                    if (accepted)
                    begin
                        ram_we    = !new_best;
                        ram_waddr = best_idx_reg;
                        ram_wdata = {rid_reg, trk_reg};
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = last_reg;
                    end
                    size_next = size_mid - SW'(1);
                    head_next = fin_trk;
                end
                else
                begin
                    ram_we    = accepted;
                    ram_waddr = size_reg[IW-1:0];
                    ram_wdata = {rid_reg, trk_reg};
                    size_next = size_mid;
                end

                // Result transaction.
                done_next = 1'b1;
                if (cmd_reg == CMD_RETIRE)
                begin
                    status_next = STATUS_OK;
                end
                else if (match_reg)
                begin
                    status_next = STATUS_DUP;
                end
                else if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next = STATUS_OK;
                end
                disp_next = dispatch;
                srid_next = dispatch ? fin_id : '0;
                strk_next = IN_TRACK_W'(dispatch ? fin_trk : head_reg);
                pend_next = PEND_W'(dispatch ? (size_mid - SW'(1)) : size_mid);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            size_reg    <= '0;
            head_reg    <= '0;
            retired_reg <= '0;
            limit_reg   <= QUEUE_LIMIT_RST;
            active_reg  <= ACTIVE_RST;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            head_reg    <= head_next;
            retired_reg <= retired_next;
            limit_reg   <= limit_next;
            active_reg  <= active_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rid_reg       <= rid_next;
        trk_reg       <= trk_next;
        issue_reg     <= issue_next;
        rd_idx_reg    <= rd_idx_next;
        match_reg     <= match_next;
        best_vld_reg  <= best_vld_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_id_reg   <= best_id_next;
        best_trk_reg  <= best_trk_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
        disp_reg      <= disp_next;
        srid_reg      <= srid_next;
        strk_reg      <= strk_next;
        pend_reg      <= pend_next;
    end

    // Ports.
    assign busy             = (state_reg != SEQ_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign dispatched       = disp_reg;
    assign served_requester = srid_reg;
    assign served_track     = strk_reg;
    assign pending_count    = pend_reg;
    assign pready           = 1'b1;
    assign prdata           = (paddr[2] == REG_ACTIVE_REQUESTERS) ?
                              APB_DATA_W'(active_reg) : APB_DATA_W'(limit_reg);

endmodule : sstf_disk_request_scheduler_top

`default_nettype wire

@@ hdl/sstf_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : sstf_ram

`default_nettype wire

@@ hdl/sstf_seek.sv @@
// Shared seek-distance unit: distance to the head and comparison with the best so far.
`default_nettype none

module sstf_seek #(
    parameter int W = 16
) (
    input  wire logic [W-1:0] cand_track,
    input  wire logic [W-1:0] head_track,
    input  wire logic [W-1:0] best_dist,
    input  wire logic         best_vld,
    output      logic [W-1:0] gap,
    output      logic         closer
);

    // Absolute track difference.
    always_comb
    begin
        if (cand_track > head_track)
        begin
            gap = cand_track - head_track;
        end
        else
        begin
            gap = head_track - cand_track;
        end
    end

    // Strictly nearer wins, so the earlier slot keeps a tie.
    assign closer = !best_vld || (gap < best_dist);

endmodule : sstf_seek

`default_nettype wire

@@ hdl/sstf_checker.sv @@
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none

module sstf_checker
    import sstf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic                  dispatched,
    input wire logic [ID_W-1:0]       served_requester
);

    // A result only follows a transaction in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

    // One result per transaction: the strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("result strobe held for more than one cycle");

    // An accepted transaction makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

    // No served requester is reported without a dispatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !dispatched) |-> (served_requester == '0))
    else $error("served requester reported without a dispatch");

endmodule : sstf_checker

bind sstf_disk_request_scheduler_top sstf_checker u_sstf_checker (.*);

`default_nettype wire
